### rtl/core/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Types, constants and arithmetic helpers for the minmod slope limiter.
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_SH    = FRAC_BITS + 1;
  // Quotient bits the divider has to produce: with the hydrostatic terms the
  // numerator magnitude stays below 2^48, so 48 + DIV_SH bits hold the whole
  // quotient and its integer part can be checked against the limit.
  localparam int QBITS     = 48 + DIV_SH;
  localparam int QCW       = $clog2(QBITS + 1);

  localparam logic [31:0] CFG_THETA = 32'd0;
  localparam logic [31:0] CFG_HSE   = 32'd1;
  localparam logic [15:0] THETA_RST = 16'd16384;

  typedef struct packed {
    logic [30:0]        cell_width;
    logic signed [31:0] value;
    logic [30:0]        density;
    logic signed [31:0] gravity;
    logic               first_cell;
    logic               last_cell;
  } plm_in_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic               last_of_run;
  } plm_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WEIGHT,
    ST_HYD,
    ST_NUM,
    ST_DIV,
    ST_THETA,
    ST_LIMIT,
    ST_OUT
  } plm_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
    if (x > 67'sd2147483647) return 32'sh7fffffff;
    if (x < -67'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

### rtl/core/plm_minmod_slope_limiter_top.sv
// ----------------------------------------------------------------------------
// plm_minmod_slope_limiter_top
// Minmod piecewise-linear slope limiter over a streamed nonuniform 1-D grid.
// ----------------------------------------------------------------------------
// Cells enter on in_valid/in_ready, one transfer per cell, as plm_in_t.
// Slopes leave on out_valid/out_ready as plm_out_t. A slope needs its right
// neighbour, so a cell's slope comes out during the following cell's work;
// the final cell yields two slopes (the second flagged last_of_run).
// Registers plm_theta (index 0) and hse_enable (index 1) are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data while the block is idle.
// Each slope runs three signed divisions one after another on a single
// restoring divider that makes one quotient bit per cycle (65 bits each),
// and the cell weight, the hydrostatic terms and the theta products share
// one 33x33 multiplier. in_ready is low until the last slope has been
// taken; when the cell only fills the window it returns after the weight
// step. A stalled out_ready holds the result register and the sequencer.
// Reset (synchronous, rst_n low) empties the window and restores the
// register defaults; theta = 1.0, balance off.
module plm_minmod_slope_limiter_top
  import plm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  plm_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output plm_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_index,
  input  logic [31:0] cfg_data
);

  plm_state_t state_r, state_nxt;

  logic [15:0] theta_r;
  logic        hse_r;
  logic        fill_r;

  // window: 0 = left, 1 = centre, 2 = right
  logic [30:0]        w_r   [3];
  logic signed [31:0] v_r   [3];
  logic signed [31:0] g_r   [3];
  logic [30:0]        p2w_r, p1w_r, curw_r;
  logic signed [31:0] p2v_r, p1v_r, curv_r;
  logic signed [31:0] p2g_r, p1g_r, curg_r;
  logic [30:0]        cur_dens_r;
  logic signed [31:0] cur_grav_r;
  logic               cur_last_r;
  logic               pend_last_r;   // second slope (final cell) to follow

  logic signed [48:0] pl_r, pr_r, pc_r;
  logic signed [47:0] h_r [3];
  logic [1:0]         step_r;        // sub-step counter inside a state
  logic [1:0]         dsel_r;        // which division
  logic signed [31:0] s_r  [3];      // sL, sC, sR
  logic               out_last_r;
  plm_out_t           out_r;
  logic               out_v_r;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // divider
  logic [49:0]  dnum_r;   // magnitude of numerator
  logic         dneg_r;
  logic [33:0]  dden_r;
  logic [QBITS-1:0]  dq_r;
  logic [QCW-1:0]    dcnt_r;
  logic [34:0]  rem_r;

  logic signed [49:0] num_sel;
  logic [33:0]        den_sel;
  logic [35:0]        trial;

  always_comb begin
    num_sel = '0;
    den_sel = '0;
    case (dsel_r)
      2'd0: begin
        num_sel = 50'(pc_r) - 50'(pl_r);
        den_sel = 34'(w_r[1]) + 34'(w_r[0]);
      end
      2'd1: begin
        num_sel = 50'(pr_r) - 50'(pl_r);
        den_sel = 34'(w_r[0]) + 34'(w_r[2]) + {2'b0, w_r[1], 1'b0};
      end
      default: begin
        num_sel = 50'(pr_r) - 50'(pc_r);
        den_sel = 34'(w_r[2]) + 34'(w_r[1]);
      end
    endcase
  end

  assign trial = {rem_r, dq_r[QBITS-1]} - {2'b0, dden_r};

  // division result assembled from quotient
  logic signed [31:0] dres;
  always_comb begin
    logic [QBITS-1:0] q;
    q = dq_r;
    if (dden_r == '0) begin
      dres = dneg_r ? 32'sh80000000 : (dnum_r == '0 ? 32'sd0 : 32'sh7fffffff);
    end else if (q[QBITS-1:DIV_SH] > (QBITS-DIV_SH)'((64'd1 << 31) >> DIV_SH)) begin
      dres = dneg_r ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      dres = dneg_r ? sat32(-$signed({2'b0, q}))
                    : sat32($signed({2'b0, q}));
    end
  end

  logic signed [31:0] thl_r, thr_r;
  logic signed [31:0] lim;
  always_comb begin
    logic signed [31:0] a, b, c, m;
    logic [32:0] bm, cm, mm;
    a = thl_r; b = s_r[1]; c = thr_r;
    m = a;
    if ((a < 0 && b > 0) || (a > 0 && b < 0)) m = 0;
    bm = b[31] ? 33'(-34'(b)) : 33'(b);
    mm = m[31] ? 33'(-34'(m)) : 33'(m);
    if (bm < mm) m = b;
    if ((b < 0 && c > 0) || (b > 0 && c < 0)) m = 0;
    cm = c[31] ? 33'(-34'(c)) : 33'(c);
    mm = m[31] ? 33'(-34'(m)) : 33'(m);
    if (cm < mm) m = c;
    lim = m;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_WEIGHT: begin
        mul_a = {2'b0, cur_dens_r};
        mul_b = {cur_grav_r[31], cur_grav_r};
      end
      ST_HYD: begin
        mul_a = {g_r[step_r][31], g_r[step_r]};
        mul_b = {2'b0, w_r[step_r]};
      end
      ST_THETA: begin
        mul_a = {17'b0, theta_r};
        mul_b = (step_r == 2'd0) ? {s_r[0][31], s_r[0]} : {s_r[2][31], s_r[2]};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_WEIGHT;
      // a cell that only fills the window produces nothing yet
      ST_WEIGHT: state_nxt = (!fill_r && !cur_last_r) ? ST_IDLE : ST_NUM;
      ST_NUM:    state_nxt = ST_HYD;
      ST_HYD:    if (step_r == 2'd2) state_nxt = ST_DIV;
      ST_DIV:    if (dcnt_r == '0 && dsel_r == 2'd2 && step_r == 2'd1)
                   state_nxt = ST_THETA;
      ST_THETA:  if (step_r == 2'd1) state_nxt = ST_LIMIT;
      ST_LIMIT:  state_nxt = ST_OUT;
      ST_OUT:    if (!out_v_r) state_nxt = pend_last_r ? ST_NUM : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      theta_r <= THETA_RST;
      hse_r   <= 1'b0;
      fill_r  <= 1'b0;
      out_v_r <= 1'b0;
      step_r  <= '0;
      dsel_r  <= '0;
      dcnt_r  <= '0;
      pend_last_r <= 1'b0;
      p2w_r <= '0; p2v_r <= '0; p2g_r <= '0;
      p1w_r <= '0; p1v_r <= '0; p1g_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_v_r && out_ready) out_v_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THETA) theta_r <= cfg_data[15:0];
        else if (cfg_index == CFG_HSE) hse_r <= cfg_data[0];
      end
      case (state_r)
        ST_IDLE: if (in_valid) begin
          curw_r     <= in_data.cell_width;
          curv_r     <= in_data.value;
          cur_dens_r <= in_data.density;
          cur_grav_r <= in_data.gravity;
          cur_last_r <= in_data.last_cell;
          pend_last_r <= 1'b0;
          if (in_data.first_cell || !fill_r) fill_r <= 1'b0;
          else fill_r <= 1'b1;  // marks: a pending slope exists
        end
        ST_WEIGHT: begin
          curg_r <= sat32(67'(mul_p >>> FRAC_BITS));
          if (!fill_r) begin
            // new grid: this cell is its own left neighbour
            p2w_r <= curw_r; p2v_r <= curv_r;
            p2g_r <= sat32(67'(mul_p >>> FRAC_BITS));
            if (!cur_last_r) begin
              // cell waits for its right neighbour
              p1w_r <= curw_r; p1v_r <= curv_r;
              p1g_r <= sat32(67'(mul_p >>> FRAC_BITS));
              fill_r <= 1'b1;
            end
          end
          pend_last_r <= cur_last_r;
        end
        ST_NUM: begin
          step_r <= '0;
          if (fill_r) begin
            // slope of the pending cell
            w_r[0] <= p2w_r; v_r[0] <= p2v_r; g_r[0] <= p2g_r;
            w_r[1] <= p1w_r; v_r[1] <= p1v_r; g_r[1] <= p1g_r;
            out_last_r <= 1'b0;
            p2w_r <= p1w_r; p2v_r <= p1v_r; p2g_r <= p1g_r;
            p1w_r <= curw_r; p1v_r <= curv_r; p1g_r <= curg_r;
            fill_r <= 1'b0;
            if (!pend_last_r) begin
              // ordinary cell: window stays loaded
            end
          end else begin
            // final cell slope
            w_r[0] <= p2w_r; v_r[0] <= p2v_r; g_r[0] <= p2g_r;
            w_r[1] <= curw_r; v_r[1] <= curv_r; g_r[1] <= curg_r;
            out_last_r <= 1'b1;
            pend_last_r <= 1'b0;
            p1w_r <= curw_r; p1v_r <= curv_r; p1g_r <= curg_r;
          end
          w_r[2] <= curw_r; v_r[2] <= curv_r; g_r[2] <= curg_r;
        end
        ST_HYD: begin
          h_r[step_r] <= 48'(mul_p >>> (FRAC_BITS + 1));
          step_r <= step_r + 2'd1;
          if (step_r == 2'd2) begin
            step_r <= '0;
            dsel_r <= '0;
          end
        end
        ST_DIV: begin
          if (step_r == 2'd0) begin
            if (dsel_r == 2'd0) begin
              if (hse_r) begin
                pl_r <= 49'(v_r[0]) - (49'(v_r[1]) - 49'(h_r[1]) - 49'(h_r[0]));
                pr_r <= 49'(v_r[2]) - (49'(v_r[1]) + 49'(h_r[1]) + 49'(h_r[2]));
                pc_r <= '0;
              end else begin
                pl_r <= 49'(v_r[0]); pr_r <= 49'(v_r[2]); pc_r <= 49'(v_r[1]);
              end
              step_r <= 2'd2;
            end else begin
              step_r <= 2'd2;
            end
          end else if (step_r == 2'd2) begin
            dneg_r <= num_sel[49];
            dnum_r <= num_sel[49] ? 50'(-num_sel) : 50'(num_sel);
            dden_r <= den_sel;
            dq_r   <= QBITS'(num_sel[49] ? 50'(-num_sel) : 50'(num_sel)) << DIV_SH;
            rem_r  <= '0;
            dcnt_r <= QCW'(QBITS);
            step_r <= 2'd3;
          end else if (step_r == 2'd3) begin
            if (dcnt_r != '0) begin
              if (!trial[35]) begin
                rem_r <= trial[34:0];
                dq_r  <= {dq_r[QBITS-2:0], 1'b1};
              end else begin
                rem_r <= {rem_r[33:0], dq_r[QBITS-1]};
                dq_r  <= {dq_r[QBITS-2:0], 1'b0};
              end
              dcnt_r <= dcnt_r - 1'b1;
            end else begin
              s_r[dsel_r] <= dres;
              step_r <= 2'd1;
            end
          end else begin
            if (dsel_r == 2'd2) begin
              step_r <= '0;
            end else begin
              dsel_r <= dsel_r + 2'd1;
              step_r <= 2'd2;
            end
          end
        end
        ST_THETA: begin
          if (step_r == 2'd0) thl_r <= sat32(67'(mul_p >>> 14));
          else thr_r <= sat32(67'(mul_p >>> 14));
          step_r <= step_r + 2'd1;
        end
        ST_LIMIT: begin
          step_r <= '0;
          out_r.slope <= lim;
          out_r.last_of_run <= out_last_r;
          out_v_r <= 1'b1;
        end
        ST_OUT: ;
        default: ;
      endcase
      if (state_r == ST_OUT && !out_v_r && !pend_last_r && cur_last_r && out_last_r)
        fill_r <= 1'b0;
      else if (state_r == ST_OUT && !out_v_r && !pend_last_r)
        fill_r <= 1'b1;
    end
  end

endmodule
